### design/lgts_pkg.sv
// Package for the LDA topic sampler: codes, defaults, widths and shared types.
// Used by every module of the block; depends on nothing.
package lgts_pkg;

  localparam int MAX_TOPICS_DEF  = 128;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int WEIGHT_W        = 64;
  localparam int BASE_W          = 56;
  localparam int VOCAB_W         = 24;
  localparam int DRAW_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int TOPIC_W         = 7;
  localparam int CFG_W           = 32;

  localparam logic [31:0] ALPHA_RST = 32'd655;
  localparam logic [31:0] BETA_RST  = 32'd65536;
  localparam logic [23:0] VOCAB_RST = 24'd0;
  localparam logic [7:0]  TIU_RST   = 8'd100;

  typedef enum logic [1:0] {
    ACT_LOAD_DOC  = 2'd0,
    ACT_LOAD_WORD = 2'd1,
    ACT_LOAD_GLB  = 2'd2,
    ACT_RESAMPLE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_VOCAB = 2'd2,
    REG_TIU   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REM_RD,
    ST_REM_WR,
    ST_BASE,
    ST_BASE_W,
    ST_T_RD,
    ST_T_MUL,
    ST_T_MUL_W,
    ST_T_DIV_W,
    ST_THR,
    ST_THR_W,
    ST_S_RD,
    ST_S_CHK,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_OUT
  } state_e;

endpackage

### design/lgts_count_table.sv
// Per-topic count table: one write and one registered read port, reset to zero.
// Uses lgts_pkg; a valid bit per entry stands in for the zero reset.
module lgts_count_table import lgts_pkg::*; #(
  parameter int DEPTH = MAX_TOPICS_DEF,
  parameter int IW    = $clog2(MAX_TOPICS_DEF),
  parameter int NB    = COUNT_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [NB-1:0] wdata_i,
  input  logic [IW-1:0] raddr_i,
  output logic [NB-1:0] rdata_o
);

  logic [NB-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [NB-1:0]    rd_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvld_q <= valid_q[raddr_i];
    end
  end

  // an entry never written reads as zero
  assign rdata_o = rvld_q ? rd_q : '0;

  a_wr_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_i |=> valid_q[$past(waddr_i)])
    else $error("written entry not marked valid");

  a_invalid_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rvld_q |-> rdata_o == '0)
    else $error("unwritten entry read non-zero");

  a_valid_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) >= $past($countones(valid_q)))
    else $error("valid bits lost");

endmodule

### design/lgts_alu.sv
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
// Uses lgts_pkg for the operation codes and control struct.
module lgts_alu import lgts_pkg::*; #(
  parameter int PW  = 103,
  parameter int MW  = 40,
  parameter int DW  = 57,
  parameter int CTW = 7
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  alu_ctl_t       ctl_i,
  input  logic [PW-1:0]  opa_i,
  input  logic [MW-1:0]  opb_i,
  input  logic [DW-1:0]  divisor_i,
  input  logic [CTW-1:0] nbits_i,
  output logic           done_o,
  output logic [PW-1:0]  result_o
);

  logic                  busy_q;
  alu_op_e               op_q;
  logic [CTW-1:0]        cnt_q;
  logic [PW-1:0]         acc_q;
  logic [PW-1:0]         a_q;
  logic [MW-1:0]         b_q;
  logic [DW-1:0]         dv_q;
  logic [PW-WEIGHT_W-1:0] hi;
  logic                  sat;
  logic [DW:0]           sh;
  logic [DW:0]           diff;
  logic                  ge;

  always_comb begin
    hi   = opa_i[PW-1:WEIGHT_W];
    sat  = PW'(hi) >= PW'(divisor_i);
    sh   = {acc_q[DW-1:0], a_q[WEIGHT_W-1]};
    ge   = sh >= {1'b0, dv_q};
    diff = sh - {1'b0, dv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      op_q   <= ctl_i.op;
      if (ctl_i.op == ALU_MUL) begin
        cnt_q <= nbits_i;
      end else if (sat) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= CTW'(WEIGHT_W);
      end
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      dv_q <= divisor_i;
      b_q  <= opb_i;
      if (ctl_i.op == ALU_MUL) begin
        acc_q <= '0;
        a_q   <= opa_i;
      end else if (sat) begin
        // quotient would overflow: saturate
        a_q <= '1;
      end else begin
        acc_q <= PW'(hi);
        a_q   <= opa_i;
      end
    end else if (busy_q && cnt_q != '0) begin
      if (op_q == ALU_MUL) begin
        if (b_q[0]) begin
          acc_q <= acc_q + a_q;
        end
        a_q <= {a_q[PW-2:0], 1'b0};
        b_q <= {1'b0, b_q[MW-1:1]};
      end else begin
        acc_q <= PW'(ge ? diff[DW-1:0] : sh[DW-1:0]);
        a_q   <= {a_q[PW-2:0], ge};
      end
    end
  end

  assign done_o   = busy_q && (cnt_q == '0);
  assign result_o = (op_q == ALU_MUL) ? acc_q : PW'(a_q[WEIGHT_W-1:0]);

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> (!busy_q || done_o))
    else $error("unit restarted while busy");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && op_q == ALU_DIV && cnt_q != '0 |-> acc_q[DW-1:0] < dv_q)
    else $error("partial remainder not below divisor");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !ctl_i.start |=> !busy_q)
    else $error("unit stays busy after done");

endmodule

### design/lda_collapsed_gibbs_topic_sampler_top.sv
// Top level of the LDA topic sampler: stream ports, config registers, sequencer,
// weight memory. Uses lgts_pkg, lgts_count_table and lgts_alu.
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tdata item fields, tuser action
// m_axis    out        m_axis_tvalid/tready      tdata new_topic
// cfg       in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// A load item is written to its table as it is accepted. A resample item runs the
// removal of a valid old topic and the base product, then per topic in use a table read,
// shift-add multiply and 64-step divide in the shared unit (no divide when the divisor
// is zero, no divide steps when the quotient saturates), then the threshold and the scan.
// Input ready is high only in idle; a result waits in the output register while
// the next item is accepted. Reset clears the count tables through valid bits.
module lda_collapsed_gibbs_topic_sampler_top import lgts_pkg::*; #(
  parameter int MAX_TOPICS = MAX_TOPICS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // topic_index[6:0], count_value[30:7], old_topic[37:31],
  // old_topic_valid[38], random_draw[70:39], zero pad[71]
  input  logic [71:0] s_axis_tdata_i,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // new_topic[6:0], zero pad[7]
  output logic [7:0]  m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int NB  = COUNT_BITS;
  localparam int IW  = $clog2(MAX_TOPICS);
  localparam int SW  = NB - 1 + FRAC_W;
  localparam int AW  = ((SW > 32) ? SW : 32) + 1;
  localparam int DW  = ((SW > BASE_W) ? SW : BASE_W) + 1;
  localparam int TW  = WEIGHT_W + IW;
  localparam int PW  = TW + DRAW_W;
  localparam int MW  = (AW > DRAW_W) ? AW : DRAW_W;
  localparam int CTW = $clog2(WEIGHT_W + 1);
  localparam logic signed [33:0] CNT_MAX = (34'sd1 <<< (NB - 1)) - 34'sd1;
  localparam logic signed [33:0] CNT_MIN = -CNT_MAX - 34'sd1;

  function automatic logic [NB-1:0] sat_cnt(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = v;
    if (v > CNT_MAX) r = CNT_MAX;
    else if (v < CNT_MIN) r = CNT_MIN;
    return r[NB-1:0];
  endfunction

  function automatic logic [SW-1:0] nn_sh(input logic [NB-1:0] c);
    return c[NB-1] ? '0 : {c[NB-2:0], {FRAC_W{1'b0}}};
  endfunction

  // item fields
  logic [TOPIC_W-1:0] in_tidx;
  logic [23:0]        in_cval;
  logic [TOPIC_W-1:0] in_old;
  logic               in_oldv;
  logic [DRAW_W-1:0]  in_draw;
  action_e            in_act;
  logic               in_acc;

  assign in_tidx = s_axis_tdata_i[6:0];
  assign in_cval = s_axis_tdata_i[30:7];
  assign in_old  = s_axis_tdata_i[37:31];
  assign in_oldv = s_axis_tdata_i[38];
  assign in_draw = s_axis_tdata_i[70:39];
  assign in_act  = action_e'(s_axis_tuser_i);

  // configuration
  logic [31:0] alpha_q, beta_q;
  logic [23:0] vocab_q;
  logic [7:0]  tiu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      beta_q  <= BETA_RST;
      vocab_q <= VOCAB_RST;
      tiu_q   <= TIU_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ALPHA: alpha_q <= cfg_data_i;
        REG_BETA:  beta_q  <= cfg_data_i;
        REG_VOCAB: vocab_q <= cfg_data_i[VOCAB_W-1:0];
        REG_TIU:   tiu_q   <= cfg_data_i[7:0];
        default:   ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [TOPIC_W-1:0] old_q;
  logic [DRAW_W-1:0]  draw_q;
  logic [IW-1:0]      last_q, t_q, chosen_q;
  logic [BASE_W-1:0]  base_q;
  logic [DW-1:0]      d_q;
  logic [TW-1:0]      total_q, run_q, thr_q, run_n;
  logic               out_valid_q;
  logic [TOPIC_W-1:0] out_topic_q;
  logic               out_load;

  // tables
  logic [IW-1:0] tab_raddr, tab_waddr;
  logic          doc_we, wrd_we, glb_we;
  logic [NB-1:0] doc_wd, wrd_wd, glb_wd, ld_val;
  logic [NB-1:0] doc_rd, wrd_rd, glb_rd;
  logic signed [33:0] delta;
  logic          ld_ok;

  // weights
  logic [WEIGHT_W-1:0] wgt_mem [MAX_TOPICS];
  logic [WEIGHT_W-1:0] wgt_rd_q, wgt_wd;
  logic                wgt_we;

  // shared unit
  alu_ctl_t       alu_ctl;
  logic [PW-1:0]  alu_opa, alu_res;
  logic [MW-1:0]  alu_opb;
  logic [CTW-1:0] alu_nbits;
  logic           alu_done;

  logic [AW-1:0]  a_val, b_val;
  logic [DW-1:0]  d_val;
  logic           rem_ok, last_topic;
  logic [IW-1:0]  last_new;

  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign ld_val     = sat_cnt(34'($signed(in_cval)));
  assign ld_ok      = 32'(in_tidx) < 32'(MAX_TOPICS);
  assign rem_ok     = in_oldv && (32'(in_old) < 32'(MAX_TOPICS));
  assign a_val      = AW'(alpha_q) + AW'(nn_sh(doc_rd));
  assign b_val      = AW'(beta_q) + AW'(nn_sh(wrd_rd));
  assign d_val      = DW'(base_q) + DW'(nn_sh(glb_rd));
  assign run_n      = run_q + TW'(wgt_rd_q);
  assign last_topic = (t_q == last_q);

  always_comb begin
    if (tiu_q == '0) last_new = '0;
    else if (32'(tiu_q) > 32'(MAX_TOPICS)) last_new = IW'(MAX_TOPICS - 1);
    else last_new = IW'(tiu_q - 8'd1);
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    alu_ctl         = '{start: 1'b0, op: ALU_MUL};
    alu_opa         = PW'(alu_res);
    alu_opb         = '0;
    alu_nbits       = '0;
    wgt_we          = 1'b0;
    wgt_wd          = alu_res[WEIGHT_W-1:0];
    doc_we          = 1'b0;
    wrd_we          = 1'b0;
    glb_we          = 1'b0;
    delta           = 34'sd1;
    tab_raddr       = t_q;
    tab_waddr       = chosen_q;
    out_load        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        tab_waddr       = IW'(in_tidx);
        if (in_acc) begin
          if (in_act == ACT_RESAMPLE) begin
            state_d = rem_ok ? ST_REM_RD : ST_BASE;
          end else if (ld_ok) begin
            doc_we = (in_act == ACT_LOAD_DOC);
            wrd_we = (in_act == ACT_LOAD_WORD);
            glb_we = (in_act == ACT_LOAD_GLB);
          end
        end
      end
      ST_REM_RD: begin
        tab_raddr = IW'(old_q);
        state_d   = ST_REM_WR;
      end
      ST_REM_WR: begin
        tab_waddr = IW'(old_q);
        delta     = -34'sd1;
        doc_we    = 1'b1;
        wrd_we    = 1'b1;
        glb_we    = 1'b1;
        state_d   = ST_BASE;
      end
      ST_BASE: begin
        alu_ctl   = '{start: 1'b1, op: ALU_MUL};
        alu_opa   = PW'(beta_q);
        alu_opb   = MW'(vocab_q);
        alu_nbits = CTW'(VOCAB_W);
        state_d   = ST_BASE_W;
      end
      ST_BASE_W: begin
        if (alu_done) state_d = ST_T_RD;
      end
      ST_T_RD: begin
        state_d = ST_T_MUL;
      end
      ST_T_MUL: begin
        alu_ctl   = '{start: 1'b1, op: ALU_MUL};
        alu_opa   = PW'(a_val);
        alu_opb   = MW'(b_val);
        alu_nbits = CTW'(AW);
        state_d   = ST_T_MUL_W;
      end
      ST_T_MUL_W: begin
        if (alu_done) begin
          if (d_q == '0) begin
            // zero divisor: weight is zero
            wgt_we  = 1'b1;
            wgt_wd  = '0;
            state_d = last_topic ? ST_THR : ST_T_RD;
          end else begin
            alu_ctl = '{start: 1'b1, op: ALU_DIV};
            alu_opa = alu_res;
            state_d = ST_T_DIV_W;
          end
        end
      end
      ST_T_DIV_W: begin
        if (alu_done) begin
          wgt_we  = 1'b1;
          state_d = last_topic ? ST_THR : ST_T_RD;
        end
      end
      ST_THR: begin
        alu_ctl   = '{start: 1'b1, op: ALU_MUL};
        alu_opa   = PW'(total_q);
        alu_opb   = MW'(draw_q);
        alu_nbits = CTW'(DRAW_W);
        state_d   = ST_THR_W;
      end
      ST_THR_W: begin
        if (alu_done) state_d = (total_q == '0) ? ST_ADD_RD : ST_S_RD;
      end
      ST_S_RD: begin
        state_d = ST_S_CHK;
      end
      ST_S_CHK: begin
        state_d = (run_n > thr_q || last_topic) ? ST_ADD_RD : ST_S_RD;
      end
      ST_ADD_RD: begin
        tab_raddr = chosen_q;
        state_d   = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        doc_we  = 1'b1;
        wrd_we  = 1'b1;
        glb_we  = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == ST_IDLE) begin
      doc_wd = ld_val;
      wrd_wd = ld_val;
      glb_wd = ld_val;
    end else begin
      doc_wd = sat_cnt(34'($signed(doc_rd)) + delta);
      wrd_wd = sat_cnt(34'($signed(wrd_rd)) + delta);
      glb_wd = sat_cnt(34'($signed(glb_rd)) + delta);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_topic_q <= TOPIC_W'(chosen_q);
    end
    unique case (state_q)
      ST_IDLE: begin
        old_q    <= in_old;
        draw_q   <= in_draw;
        last_q   <= last_new;
        t_q      <= '0;
        total_q  <= '0;
        chosen_q <= '0;
      end
      ST_BASE_W: begin
        if (alu_done) base_q <= alu_res[BASE_W-1:0];
      end
      ST_T_MUL: begin
        d_q <= d_val;
      end
      ST_T_MUL_W: begin
        if (alu_done && d_q == '0 && !last_topic) t_q <= t_q + 1'b1;
      end
      ST_T_DIV_W: begin
        if (alu_done) begin
          total_q <= total_q + TW'(alu_res[WEIGHT_W-1:0]);
          if (!last_topic) t_q <= t_q + 1'b1;
        end
      end
      ST_THR_W: begin
        if (alu_done) begin
          thr_q <= alu_res[PW-1:DRAW_W];
          t_q   <= '0;
          run_q <= '0;
        end
      end
      ST_S_CHK: begin
        run_q <= run_n;
        if (run_n > thr_q || last_topic) chosen_q <= t_q;
        else t_q <= t_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wgt_we) begin
      wgt_mem[t_q] <= wgt_wd;
    end
    wgt_rd_q <= wgt_mem[t_q];
  end

  lgts_count_table #(.DEPTH(MAX_TOPICS), .IW(IW), .NB(NB)) u_doc (
    .clk_i, .rst_ni, .we_i(doc_we), .waddr_i(tab_waddr), .wdata_i(doc_wd),
    .raddr_i(tab_raddr), .rdata_o(doc_rd)
  );

  lgts_count_table #(.DEPTH(MAX_TOPICS), .IW(IW), .NB(NB)) u_word (
    .clk_i, .rst_ni, .we_i(wrd_we), .waddr_i(tab_waddr), .wdata_i(wrd_wd),
    .raddr_i(tab_raddr), .rdata_o(wrd_rd)
  );

  lgts_count_table #(.DEPTH(MAX_TOPICS), .IW(IW), .NB(NB)) u_glb (
    .clk_i, .rst_ni, .we_i(glb_we), .waddr_i(tab_waddr), .wdata_i(glb_wd),
    .raddr_i(tab_raddr), .rdata_o(glb_rd)
  );

  lgts_alu #(.PW(PW), .MW(MW), .DW(DW), .CTW(CTW)) u_alu (
    .clk_i, .rst_ni, .ctl_i(alu_ctl), .opa_i(alu_opa), .opb_i(alu_opb),
    .divisor_i(d_q), .nbits_i(alu_nbits), .done_o(alu_done), .result_o(alu_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_topic_q};

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_S_CHK && last_topic |=> state_q == ST_ADD_RD)
    else $error("scan ran past the last topic");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == ST_BASE_W || state_q == ST_T_MUL_W ||
                  state_q == ST_T_DIV_W || state_q == ST_THR_W))
    else $error("shared unit finished outside a wait state");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && (!out_valid_q || m_axis_tready_i) |=> out_valid_q)
    else $error("finished request not presented");

endmodule
